FILE: rtl/pcrm_pkg.sv
package pcrm_pkg;

  localparam int unsigned Entries  = 4096;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned FracBits = 16;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned CountW   = 16;

  localparam logic OP_CELL = 1'b0;
  localparam logic OP_FACE = 1'b1;

  localparam logic [0:0] REG_COUNT = 1'b0;
  localparam logic [0:0] REG_RECIP = 1'b1;

  typedef logic signed [31:0] word_t;

  // Clamp a wide signed value to 32 bits.
  function automatic word_t sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -96'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/pcrm_ram.sv
module pcrm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/pcrm_lane.sv
// One statistic lane: registered mean update plus the differences d0 and d1 that feed the second-moment stage.
module pcrm_lane import pcrm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  word_t                     x_i,
  input  word_t                     mean_i,
  input  logic [RecipW-1:0]         recip_i,
  output logic signed [33:0]        d0_o,
  output logic signed [33:0]        d1_o,
  output word_t                     mean_o
);

  logic signed [33:0] d0_q;
  logic signed [33:0] d0_d;
  logic signed [52:0] prod;
  logic signed [95:0] scaled;
  word_t              mean_q;
  word_t              mean_d;
  word_t              x_q;

  assign d0_d   = 34'(x_i) - 34'(mean_i);
  assign prod   = 53'(d0_d) * $signed({1'b0, recip_i});
  assign scaled = 96'(prod + 53'sd32768) >>> 16;
  assign mean_d = sat32(96'(mean_i) + scaled);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q   <= d0_d;
      mean_q <= mean_d;
      x_q    <= x_i;
    end
  end

  assign d0_o   = d0_q;
  assign mean_o = mean_q;
  assign d1_o   = 34'(x_q) - 34'(mean_q);

endmodule

FILE: rtl/pcrm_moment.sv
// Second-moment update: sat(S((n-1)*old + P(d0, d1))), one register stage.
module pcrm_moment import pcrm_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [33:0]  d0_i,
  input  logic signed [33:0]  d1_i,
  input  word_t               old_i,
  input  logic [CountW-1:0]   weight_i,
  input  logic [RecipW-1:0]   recip_i,
  output word_t               res_o
);

  logic signed [67:0] pp;
  logic signed [67:0] pfix;
  logic signed [48:0] wold;
  logic signed [68:0] sum_q;
  logic signed [68:0] sum_d;
  logic signed [68:0] hi;
  logic [15:0]        lo;
  logic signed [87:0] hi_r;
  logic [33:0]        lo_r;
  logic signed [95:0] tot;

  assign pp    = 68'(d0_i) * 68'(d1_i);
  assign pfix  = (pp + (68'sd1 <<< (FracBits - 1))) >>> FracBits;
  assign wold  = $signed({1'b0, weight_i}) * 49'(old_i);
  assign sum_d = 69'(pfix) + 69'(wold);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign hi   = sum_q >>> 16;
  assign lo   = sum_q[15:0];
  assign hi_r = 88'(hi) * $signed({1'b0, recip_i});
  assign lo_r = 34'(lo) * 34'(recip_i) + 34'd32768;
  assign tot  = 96'(hi_r) + 96'(lo_r[33:16]);

  // scaled moment feeds the merge stage directly
  assign res_o = sat32(tot);

endmodule

FILE: rtl/per_cell_running_mean_var_cov_unit.sv
// Streaming per-entry running mean / variance / covariance. One request is
// accepted per cycle while the output is not stalled and requests go to
// different entries; a result passes through store read, mean lanes, moment
// sum and moment scale merged into the output register. A request to an
// entry still in the pipeline waits until that entry is written back.
// A stalled result holds the whole pipeline. Three mean lanes and
// six moment units work side by side; a merging stage writes the stores and
// forms the result. After reset a clearing pass sweeps all 4096 entries, one
// per cycle, during which no request is accepted.
module per_cell_running_mean_var_cov_unit import pcrm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [11:0]           cell_index_i,
  input  logic signed [31:0]    sample_a_i,
  input  logic signed [31:0]    sample_b_i,
  input  logic signed [31:0]    sample_c_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [11:0]           entry_index_o,
  output logic signed [31:0]    mean_a_o,
  output logic signed [31:0]    mean_b_o,
  output logic signed [31:0]    mean_c_o,
  output logic signed [31:0]    var_a_o,
  output logic signed [31:0]    var_b_o,
  output logic signed [31:0]    var_c_o,
  output logic signed [31:0]    cov_ab_o,
  output logic signed [31:0]    cov_ac_o,
  output logic signed [31:0]    cov_bc_o
);

  localparam int unsigned StW = 9 * 32;
  localparam int unsigned NSt = 4;

  typedef struct packed {
    logic             op;
    logic [11:0]      idx;
    word_t [2:0]      x;
  } req_t;

  logic [CountW-1:0] count_q;
  logic [RecipW-1:0] recip_q;
  logic [CountW-1:0] weight;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd1;
      recip_q <= 17'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COUNT: count_q <= pwdata[15:0];
        REG_RECIP: recip_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_COUNT: prdata = {16'd0, count_q};
      REG_RECIP: prdata = {15'd0, recip_q};
      default:   prdata = '0;
    endcase
  end
  assign weight = (count_q == '0) ? '0 : count_q - 16'd1;

  // clearing pass
  logic            clr_q;
  logic [IdxW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
      if (clr_cnt_q == IdxW'(Entries - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // pipeline: s1 read data, s2 mean, s3 sum, s4 result/writeback
  logic [NSt:1] v_q;
  req_t         r_q [1:NSt];
  logic         adv;
  logic         acc;
  logic         hazard;
  logic         o_v_q;

  // hold a request whose entry has not been written back yet
  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= NSt; i++) begin
      if (v_q[i] && r_q[i].op == operation_i && r_q[i].idx == cell_index_i) begin
        hazard = 1'b1;
      end
    end
  end

  assign adv        = !(o_v_q && out_stall_i);
  assign in_stall_o = clr_q || !adv || hazard;
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSt-1:1], acc};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[1] <= '{op: operation_i, idx: cell_index_i,
                  x: {sample_c_i, sample_b_i, sample_a_i}};
      r_q[2] <= r_q[1];
      r_q[3] <= r_q[2];
      r_q[4] <= r_q[3];
    end
  end

  // one wide store holding [means(3), vars(3), covs(3)]; face uses own store
  logic [StW-1:0] cell_rd;
  logic [63:0]    face_rd;
  logic [StW-1:0] cell_wr;
  logic [63:0]    face_wr;
  logic           cell_we;
  logic           face_we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;

  assign raddr = adv ? cell_index_i[IdxW-1:0] : r_q[1].idx[IdxW-1:0];

  pcrm_ram #(.Width(StW), .Depth(Entries)) u_cell (
    .clk_i(clk_i), .we_i(cell_we), .waddr_i(waddr), .wdata_i(cell_wr),
    .raddr_i(raddr), .rdata_o(cell_rd)
  );
  pcrm_ram #(.Width(64), .Depth(Entries)) u_face (
    .clk_i(clk_i), .we_i(face_we), .waddr_i(waddr), .wdata_i(face_wr),
    .raddr_i(raddr), .rdata_o(face_rd)
  );

  word_t [8:0] res_q;
  word_t [8:0] res_d;

  word_t [8:0] st1;
  always_comb begin
    if (r_q[1].op == OP_CELL) begin
      st1 = cell_rd;
    end else begin
      st1 = '0;
      st1[0] = face_rd[31:0];
      st1[3] = face_rd[63:32];
    end
  end

  word_t [8:0] old2_q;
  word_t [8:0] old3_q;
  word_t [2:0] mean2;
  logic signed [33:0] d0 [3];
  logic signed [33:0] d1 [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      old2_q <= st1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      pcrm_lane u_lane (
        .clk_i(clk_i), .en_i(adv), .x_i(r_q[2].x[g]), .mean_i(old2_q[g]),
        .recip_i(recip_q), .d0_o(d0[g]), .d1_o(d1[g]), .mean_o(mean2[g])
      );
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (adv) begin
      old3_q <= old2_q;
    end
  end

  word_t mom [6];
  logic signed [33:0] ma [6];
  logic signed [33:0] mb [6];
  assign ma[0] = d0[0]; assign mb[0] = d1[0];
  assign ma[1] = d0[1]; assign mb[1] = d1[1];
  assign ma[2] = d0[2]; assign mb[2] = d1[2];
  assign ma[3] = d0[0]; assign mb[3] = d1[1];
  assign ma[4] = d0[0]; assign mb[4] = d1[2];
  assign ma[5] = d0[1]; assign mb[5] = d1[2];

  word_t [2:0] mean4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mean4_q <= mean2;
    end
  end

  generate
    for (g = 0; g < 6; g++) begin : g_mom
      pcrm_moment u_mom (
        .clk_i(clk_i), .en_i(adv), .d0_i(ma[g]), .d1_i(mb[g]),
        .old_i(old3_q[3 + g]), .weight_i(weight), .recip_i(recip_q),
        .res_o(mom[g])
      );
    end
  endgenerate

  // merge: lane means and scaled moments line up with r_q[4]
  always_comb begin
    res_d = '0;
    res_d[0] = mean4_q[0];
    res_d[3] = mom[0];
    if (r_q[4].op == OP_CELL) begin
      res_d[1] = mean4_q[1];
      res_d[2] = mean4_q[2];
      res_d[4] = mom[1];
      res_d[5] = mom[2];
      res_d[6] = mom[3];
      res_d[7] = mom[4];
      res_d[8] = mom[5];
    end
  end

  logic [11:0] o_idx_q;
  assign waddr   = clr_q ? clr_cnt_q : r_q[4].idx[IdxW-1:0];
  assign cell_we = clr_q || (adv && v_q[4] && r_q[4].op == OP_CELL);
  assign face_we = clr_q || (adv && v_q[4] && r_q[4].op == OP_FACE);
  assign cell_wr = clr_q ? '0 : res_d;
  assign face_wr = clr_q ? '0 : {res_d[3], res_d[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv) begin
      o_v_q <= v_q[4];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= res_d;
      o_idx_q <= r_q[4].idx;
    end
  end

  assign out_valid_o   = o_v_q;
  assign entry_index_o = o_idx_q;
  assign mean_a_o = res_q[0];
  assign mean_b_o = res_q[1];
  assign mean_c_o = res_q[2];
  assign var_a_o  = res_q[3];
  assign var_b_o  = res_q[4];
  assign var_c_o  = res_q[5];
  assign cov_ab_o = res_q[6];
  assign cov_ac_o = res_q[7];
  assign cov_bc_o = res_q[8];

endmodule

FILE: verif/per_cell_running_mean_var_cov_unit_tb.sv
`timescale 1ns / 1ps

module per_cell_running_mean_var_cov_unit_tb import pcrm_pkg::*; ();

  localparam int WatchdogLimit = 20000;
  localparam int MaxReports    = 10;

  typedef struct {
    logic [11:0] idx;
    word_t       st[9];
  } stats_t;

  class stats_scoreboard;
    int unsigned count_q;
    int unsigned recip_q;
    word_t cmean[Entries][3];
    word_t cvar[Entries][3];
    word_t ccov[Entries][3];
    word_t fmean[Entries];
    word_t fvar[Entries];
    stats_t pending[$];
    int errors;
    int checked;

    function void clear();
      count_q = 1;
      recip_q = 65536;
      for (int e = 0; e < Entries; e++) begin
        for (int k = 0; k < 3; k++) begin
          cmean[e][k] = 0;
          cvar[e][k]  = 0;
          ccov[e][k]  = 0;
        end
        fmean[e] = 0;
        fvar[e]  = 0;
      end
    endfunction

    function longint floor_shr(longint v, int n);
      return v >>> n;
    endfunction

    function longint scale(longint y);
      longint hi, lo;
      hi = floor_shr(y, 16);
      lo = y - hi * 65536;
      return hi * longint'(recip_q) + ((lo * longint'(recip_q) + 32768) >>> 16);
    endfunction

    function longint fix_mul(longint a, longint b);
      longint hi, lo;
      hi = floor_shr(b, FracBits);
      lo = b - hi * (longint'(1) << FracBits);
      return a * hi + floor_shr(a * lo + (longint'(1) << (FracBits - 1)), FracBits);
    endfunction

    function word_t clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return word_t'(v);
    endfunction

    function word_t moment(word_t old, longint d0, longint d1);
      longint w;
      w = (count_q > 0) ? longint'(count_q) - 1 : 0;
      return clamp(scale(w * longint'(old) + fix_mul(d0, d1)));
    endfunction

    function void note_request(logic op, logic [11:0] idx, word_t a, word_t b, word_t c);
      stats_t r;
      longint x[3], d0[3], d1[3];
      word_t mn[3];
      int e;
      e = idx % Entries;
      r.idx = idx;
      for (int k = 0; k < 9; k++) r.st[k] = 0;
      x[0] = a; x[1] = b; x[2] = c;
      if (op == OP_CELL) begin
        for (int k = 0; k < 3; k++) begin
          d0[k] = x[k] - longint'(cmean[e][k]);
          mn[k] = clamp(longint'(cmean[e][k]) + scale(d0[k]));
          d1[k] = x[k] - longint'(mn[k]);
        end
        for (int k = 0; k < 3; k++) begin
          cvar[e][k]  = moment(cvar[e][k], d0[k], d1[k]);
          cmean[e][k] = mn[k];
        end
        ccov[e][0] = moment(ccov[e][0], d0[0], d1[1]);
        ccov[e][1] = moment(ccov[e][1], d0[0], d1[2]);
        ccov[e][2] = moment(ccov[e][2], d0[1], d1[2]);
        for (int k = 0; k < 3; k++) begin
          r.st[k]     = cmean[e][k];
          r.st[3 + k] = cvar[e][k];
          r.st[6 + k] = ccov[e][k];
        end
      end else begin
        d0[0] = x[0] - longint'(fmean[e]);
        mn[0] = clamp(longint'(fmean[e]) + scale(d0[0]));
        d1[0] = x[0] - longint'(mn[0]);
        fvar[e]  = moment(fvar[e], d0[0], d1[0]);
        fmean[e] = mn[0];
        r.st[0] = fmean[e];
        r.st[3] = fvar[e];
      end
      pending.push_back(r);
    endfunction

    function void check_result(stats_t got);
      stats_t exp_r;
      bit bad;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("unexpected result for entry %0d", got.idx);
        return;
      end
      exp_r = pending.pop_front();
      bad = (exp_r.idx !== got.idx);
      for (int k = 0; k < 9; k++) if (exp_r.st[k] !== got.st[k]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("mismatch entry exp %0d got %0d", exp_r.idx, got.idx);
          for (int k = 0; k < 9; k++)
            $display("  stat %0d exp %h got %h", k, exp_r.st[k], got.st[k]);
        end
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, operation_i;
  logic [11:0] cell_index_i;
  word_t sample_a_i, sample_b_i, sample_c_i;
  logic out_valid_o, out_stall_i;
  logic [11:0] entry_index_o;
  word_t mean_a_o, mean_b_o, mean_c_o, var_a_o, var_b_o, var_c_o;
  word_t cov_ab_o, cov_ac_o, cov_bc_o;

  per_cell_running_mean_var_cov_unit i_dut (.*);

  stats_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;
  int sent, cell_reqs, face_reqs;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stall, check on accept
  always @(posedge clk_i) begin
    stats_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.idx = entry_index_o;
        got.st[0] = mean_a_o; got.st[1] = mean_b_o; got.st[2] = mean_c_o;
        got.st[3] = var_a_o;  got.st[4] = var_b_o;  got.st[5] = var_c_o;
        got.st[6] = cov_ab_o; got.st[7] = cov_ac_o; got.st[8] = cov_bc_o;
        sb.check_result(got);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on accept activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] reg_sel, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_sel, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_sel == REG_COUNT) sb.count_q = value[15:0];
    else sb.recip_q = value[16:0];
  endtask

  task automatic set_count(int unsigned n, int unsigned r);
    write_reg(REG_COUNT, n);
    write_reg(REG_RECIP, r);
  endtask

  // drop valid and wait for every expected result
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // valid stays high after the accepting edge; the next send or drain
  // drives it in the same time step
  task automatic send(logic op, logic [11:0] idx, word_t a, word_t b, word_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; operation_i <= op; cell_index_i <= idx;
    sample_a_i <= a; sample_b_i <= b; sample_c_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, idx, a, b, c);
    sent++;
    if (op == OP_CELL) cell_reqs++; else face_reqs++;
  endtask

  function automatic word_t rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return word_t'($urandom_range(131072)) - 65536;
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      // keep to a few entries so statistics accumulate
      send($urandom_range(1), ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(7)),
           rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  initial begin
    int unsigned n;
    sb = new();
    sb.clear();
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; operation_i = OP_CELL; cell_index_i = 0;
    sample_a_i = 0; sample_b_i = 0; sample_c_i = 0; out_stall_i = 0;
    send_idle_pct = 0; recv_idle_pct = 0; idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, both operations, wrap-free full index, zero count
    send(OP_CELL, 12'd0, 32'sh7fffffff, 32'sh80000000, 0);
    send(OP_CELL, 12'd0, 32'sh80000000, 32'sh7fffffff, 32'sh00010000);
    send(OP_FACE, 12'hfff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send(OP_FACE, 12'hfff, 32'sh7fffffff, 0, 0);
    send(OP_CELL, 12'hfff, -1, 1, 32'shffff0000);
    send(OP_CELL, 12'hfff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
    drain();
    set_count(2, 32768);
    send(OP_CELL, 12'd0, 32'sh00030000, 32'shfffd0000, 32'sh00008000);
    send(OP_FACE, 12'd5, 32'sh00020000, 0, 0);
    send(OP_FACE, 12'd5, 32'shfffe0000, 0, 0);
    drain();
    set_count(0, 1);
    send(OP_CELL, 12'd1, 32'sh12345678, 32'shedcba987, 1);
    send(OP_FACE, 12'd1, 32'shdeadbeef, 0, 0);
    drain();
    set_count(65535, 65536);
    send(OP_CELL, 12'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send(OP_FACE, 12'd5, 32'sh7fffffff, 0, 0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 36 : 0;
      for (int s = 0; s < 3; s++) begin
        drain();
        case ($urandom_range(3))
          0: n = 1;
          1: n = 65535;
          default: n = $urandom_range(2, 100);
        endcase
        set_count(n, (65536 + n / 2) / n);
        random_phase(56);
      end
    end
    drain();
    n = $urandom_range(1, 20);
    set_count(n, $urandom_range(1, 65536));
    random_phase(20);

    drain();
    recv_idle_pct = 0;
    $display("%0d requests (%0d cell, %0d face), %0d results checked, %0d errors",
             sent, cell_reqs, face_reqs, sb.checked, sb.errors);
    $display("covered count extremes, zero count, mismatched reciprocal, saturation");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pcrm_pkg.sv
rtl/pcrm_ram.sv
rtl/pcrm_lane.sv
rtl/pcrm_moment.sv
rtl/per_cell_running_mean_var_cov_unit.sv
verif/per_cell_running_mean_var_cov_unit_tb.sv
